@@ src/frt_pkg.sv @@
`timescale 1ns / 1ps

package frt_pkg;

  localparam int unsigned SlotsDefault   = 4;
  localparam int unsigned MapBitsDefault = 256;
  localparam int unsigned HeaderBytes    = 8;
  localparam logic [15:0] MaxTotal       = 16'hFFF0;
  localparam logic [31:0] TimeoutReset   = 32'd2000;
  localparam int unsigned SlotIdxW       = 4;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_NO_SLOT   = 3'd3,
    ST_MISMATCH  = 3'd4,
    ST_LAST_BIG  = 3'd5,
    ST_SIZE_MIS  = 3'd6,
    ST_OVERFLOW  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LOOK,
    FSM_RMW,
    FSM_PUSH
  } fsm_e;

  // Result of the slot search in the lookup cycle.
  typedef struct packed {
    logic                hit;
    logic                opened;
    logic                no_slot;
    logic [SlotIdxW-1:0] slot;
  } lkp_t;

  // Per-session record kept in memory.
  typedef struct packed {
    logic [15:0] cmd;
    logic [15:0] total;
    logic [7:0]  count;
    logic [7:0]  received;
    logic [15:0] bytes;
    logic [15:0] chunk;
  } rec_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [SlotIdxW-1:0] slot;
    logic [15:0] write_offset;
    logic [15:0] write_len;
    logic        complete;
    logic [15:0] done_cmd;
    logic [15:0] done_len;
  } res_t;

endpackage

@@ src/frt_slot_table.sv @@
`timescale 1ns / 1ps

module frt_slot_table #(
  parameter int unsigned SLOTS = frt_pkg::SlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [31:0]                   timeout_i,
  input  logic [31:0]                   now_i,
  input  logic [15:0]                   sid_i,
  input  logic                          flen_ok_i,
  input  logic                          look_en_i,
  input  logic                          drop_en_i,
  input  logic [frt_pkg::SlotIdxW-1:0]  drop_slot_i,
  output frt_pkg::lkp_t                 lkp_o,
  output logic [SLOTS-1:0]              exp_o
);

  logic [SLOTS-1:0] act_q;
  logic [15:0]      ses_q [SLOTS];
  logic [31:0]      tim_q [SLOTS];
  logic [SLOTS-1:0] live;
  logic             hit, free;
  logic [frt_pkg::SlotIdxW-1:0] fslot, frs;

  always_comb begin
    hit   = 1'b0;
    free  = 1'b0;
    fslot = '0;
    frs   = '0;
    for (int s = 0; s < SLOTS; s++) begin
      exp_o[s] = act_q[s] && ((now_i - tim_q[s]) > timeout_i);
      live[s]  = act_q[s] && !exp_o[s];
      if (!hit && live[s] && ses_q[s] == sid_i) begin
        hit   = 1'b1;
        fslot = frt_pkg::SlotIdxW'(s);
      end
      if (!free && !live[s]) begin
        free = 1'b1;
        frs  = frt_pkg::SlotIdxW'(s);
      end
    end
    lkp_o.hit     = hit;
    lkp_o.opened  = !hit && free && flen_ok_i;
    lkp_o.no_slot = !hit && !free;
    lkp_o.slot    = hit ? fslot : frs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
    end else begin
      for (int s = 0; s < SLOTS; s++) begin
        if (look_en_i) begin
          if (exp_o[s]) act_q[s] <= 1'b0;
          if ((lkp_o.hit || lkp_o.opened) && lkp_o.slot == frt_pkg::SlotIdxW'(s)) begin
            act_q[s] <= 1'b1;
          end
        end
        if (drop_en_i && drop_slot_i == frt_pkg::SlotIdxW'(s)) act_q[s] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < SLOTS; s++) begin
      if (look_en_i && (lkp_o.hit || lkp_o.opened) &&
          lkp_o.slot == frt_pkg::SlotIdxW'(s)) begin
        ses_q[s] <= sid_i;
        tim_q[s] <= now_i;
      end
    end
  end

endmodule

@@ src/frt_rec_mem.sv @@
`timescale 1ns / 1ps

module frt_rec_mem #(
  parameter int unsigned SLOTS    = frt_pkg::SlotsDefault,
  parameter int unsigned MAP_BITS = frt_pkg::MapBitsDefault,
  localparam int unsigned AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output frt_pkg::rec_t        rd_rec_o,
  output logic [MAP_BITS-1:0]  rd_map_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  frt_pkg::rec_t        wr_rec_i,
  input  logic [MAP_BITS-1:0]  wr_map_i
);

  frt_pkg::rec_t       rec_mem [SLOTS];
  logic [MAP_BITS-1:0] map_mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rec_mem[wr_addr_i] <= wr_rec_i;
      map_mem[wr_addr_i] <= wr_map_i;
    end
    if (rd_en_i) begin
      rd_rec_o <= rec_mem[rd_addr_i];
      rd_map_o <= map_mem[rd_addr_i];
    end
  end

endmodule

@@ src/fragment_reassembly_tracker.sv @@
`timescale 1ns / 1ps
// Channel  | Handshake             | Payload
// in       | in_valid_i/in_stall_o | msg_len_i .. now_ms_i
// out      | out_valid_o/out_stall_i | status_o .. expired_mask_o
// cfg      | cfg_we_i              | cfg_wdata_i (timeout_ms)
// A header is captured, then goes through slot lookup with timeout sweep,
// record read-modify-write, and push into the output register.
// A header rejected at lookup (bad header or no free slot) skips the record
// read-modify-write. One item is in flight at a time, so no forwarding
// between items is needed.
// Reset clears the slot valid bits and the control state and sets the timeout to 2000.
// A stall on the output holds the finished beat; the next header is taken
// while it waits.

module fragment_reassembly_tracker #(
  parameter int unsigned SLOTS    = frt_pkg::SlotsDefault,
  parameter int unsigned MAP_BITS = frt_pkg::MapBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] msg_len_i,
  input  logic [15:0] orig_cmd_i,
  input  logic [15:0] session_id_i,
  input  logic [15:0] full_len_i,
  input  logic [7:0]  frag_idx_i,
  input  logic [7:0]  frag_count_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  slot_o,
  output logic [15:0] write_offset_o,
  output logic [15:0] write_len_o,
  output logic        complete_o,
  output logic [15:0] done_cmd_o,
  output logic [15:0] done_len_o,
  output logic [3:0]  expired_mask_o
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned BW = $clog2(MAP_BITS);

  frt_pkg::fsm_e state_q, state_d;
  logic [31:0] timeout_q;
  logic [15:0] msg_q, cmd_q, sid_q, flen_q;
  logic [7:0]  idx_q, cnt_q;
  logic [31:0] now_q;
  logic [15:0] chunk;
  logic        bad_hdr, flen_ok;
  frt_pkg::lkp_t lkp, lkp_q;
  logic [SLOTS-1:0] exp, mask_q, mask_d;
  logic        look_en, drop_en;
  frt_pkg::res_t res_q, res_d;
  frt_pkg::rec_t rd_rec, wr_rec;
  logic [MAP_BITS-1:0] rd_map, cur_map, wr_map;
  logic        wr_en;
  frt_pkg::rec_t cur;
  logic        mism, dup, is_last, accept_ok, compl;
  logic [15:0] learned;
  logic [23:0] off;
  logic [24:0] endp;
  logic [7:0]  recv_n;
  logic [15:0] bytes_n;
  logic [BW-1:0] bit_idx;
  logic        out_load;

  assign in_stall_o = (state_q != frt_pkg::FSM_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) timeout_q <= frt_pkg::TimeoutReset;
    else if (cfg_we_i) timeout_q <= cfg_wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      msg_q  <= msg_len_i;
      cmd_q  <= orig_cmd_i;
      sid_q  <= session_id_i;
      flen_q <= full_len_i;
      idx_q  <= frag_idx_i;
      cnt_q  <= frag_count_i;
      now_q  <= now_ms_i;
    end
  end

  assign chunk   = (msg_q >= 16'(frt_pkg::HeaderBytes)) ?
                   msg_q - 16'(frt_pkg::HeaderBytes) : 16'd0;
  assign bad_hdr = (msg_q < 16'(frt_pkg::HeaderBytes)) || (cnt_q == 8'd0) ||
                   (idx_q >= cnt_q) || ({1'b0, cnt_q} > 9'(MAP_BITS));
  assign flen_ok = (flen_q != 16'd0) && (flen_q <= frt_pkg::MaxTotal);
  assign look_en = (state_q == frt_pkg::FSM_LOOK) && !bad_hdr;

  frt_slot_table #(.SLOTS(SLOTS)) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timeout_i   (timeout_q),
    .now_i       (now_q),
    .sid_i       (sid_q),
    .flen_ok_i   (flen_ok),
    .look_en_i   (look_en),
    .drop_en_i   (drop_en),
    .drop_slot_i (lkp_q.slot),
    .lkp_o       (lkp),
    .exp_o       (exp)
  );

  frt_rec_mem #(.SLOTS(SLOTS), .MAP_BITS(MAP_BITS)) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (look_en),
    .rd_addr_i (lkp.slot[AW-1:0]),
    .rd_rec_o  (rd_rec),
    .rd_map_o  (rd_map),
    .wr_en_i   (wr_en),
    .wr_addr_i (lkp_q.slot[AW-1:0]),
    .wr_rec_i  (wr_rec),
    .wr_map_i  (wr_map)
  );

  // A freshly opened session ignores whatever the memory held for its slot.
  always_comb begin
    if (lkp_q.opened) begin
      cur.cmd      = cmd_q;
      cur.total    = flen_q;
      cur.count    = cnt_q;
      cur.received = 8'd0;
      cur.bytes    = 16'd0;
      cur.chunk    = 16'd0;
      cur_map      = '0;
    end else begin
      cur     = rd_rec;
      cur_map = rd_map;
    end
    bit_idx   = idx_q[BW-1:0];
    mism      = (cur.cmd != cmd_q) || (cur.count != cnt_q) || (cur.total != flen_q);
    dup       = cur_map[bit_idx];
    is_last   = (idx_q == cnt_q - 8'd1);
    learned   = (cur.chunk == 16'd0) ? chunk : cur.chunk;
    off       = is_last ? {8'd0, flen_q - chunk} : idx_q * learned;
    endp      = {1'b0, off} + {9'd0, chunk};
    recv_n    = cur.received + 8'd1;
    bytes_n   = cur.bytes + chunk;
    accept_ok = 1'b0;
    compl     = 1'b0;
    wr_rec    = cur;
    wr_rec.received = recv_n;
    wr_rec.bytes    = bytes_n;
    wr_rec.chunk    = is_last ? cur.chunk : learned;
    wr_map    = cur_map;
    wr_map[bit_idx] = 1'b1;

    res_d              = res_q;
    res_d.write_len    = chunk;
    res_d.write_offset = 16'd0;
    res_d.complete     = 1'b0;
    res_d.slot         = lkp_q.slot;
    res_d.done_cmd     = cur.cmd;
    res_d.done_len     = cur.total;
    drop_en            = 1'b0;
    if (mism) begin
      res_d.status = frt_pkg::ST_MISMATCH;
      drop_en      = 1'b1;
    end else if (dup) begin
      res_d.status = frt_pkg::ST_DUPLICATE;
    end else if (is_last && chunk > flen_q) begin
      res_d.status = frt_pkg::ST_LAST_BIG;
      drop_en      = 1'b1;
    end else if (!is_last && cur.chunk != 16'd0 && chunk != cur.chunk) begin
      res_d.status = frt_pkg::ST_SIZE_MIS;
      drop_en      = 1'b1;
    end else if (endp > {9'd0, flen_q}) begin
      res_d.status = frt_pkg::ST_OVERFLOW;
      drop_en      = 1'b1;
    end else begin
      accept_ok          = 1'b1;
      compl              = (recv_n == cnt_q) && (bytes_n == flen_q);
      res_d.status       = frt_pkg::ST_ACCEPTED;
      res_d.write_offset = off[15:0];
      res_d.complete     = compl;
      drop_en            = compl;
    end

    if (state_q == frt_pkg::FSM_LOOK) begin
      res_d.status       = frt_pkg::ST_BAD_HDR;
      res_d.slot         = '0;
      res_d.write_offset = 16'd0;
      res_d.complete     = 1'b0;
      res_d.done_cmd     = 16'd0;
      res_d.done_len     = 16'd0;
      if (!bad_hdr && lkp.no_slot) res_d.status = frt_pkg::ST_NO_SLOT;
    end
    if (state_q != frt_pkg::FSM_RMW) drop_en = 1'b0;
    wr_en = (state_q == frt_pkg::FSM_RMW) && accept_ok && !compl;
  end

  assign out_load = (state_q == frt_pkg::FSM_PUSH) && (!out_valid_o || !out_stall_i);

  always_comb begin
    state_d = state_q;
    mask_d  = mask_q;
    case (state_q)
      frt_pkg::FSM_IDLE: begin
        if (in_valid_i) state_d = frt_pkg::FSM_LOOK;
      end
      frt_pkg::FSM_LOOK: begin
        mask_d = bad_hdr ? '0 : exp;
        if (!bad_hdr && (lkp.hit || lkp.opened)) state_d = frt_pkg::FSM_RMW;
        else state_d = frt_pkg::FSM_PUSH;
      end
      frt_pkg::FSM_RMW: state_d = frt_pkg::FSM_PUSH;
      frt_pkg::FSM_PUSH: begin
        if (out_load) state_d = frt_pkg::FSM_IDLE;
      end
      default: state_d = frt_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frt_pkg::FSM_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    if (state_q == frt_pkg::FSM_LOOK) lkp_q <= lkp;
    if (state_q == frt_pkg::FSM_LOOK || state_q == frt_pkg::FSM_RMW) res_q <= res_d;
    if (out_load) begin
      status_o       <= res_q.status;
      slot_o         <= 2'(res_q.slot);
      write_offset_o <= res_q.write_offset;
      write_len_o    <= res_q.write_len;
      complete_o     <= res_q.complete;
      done_cmd_o     <= res_q.done_cmd;
      done_len_o     <= res_q.done_len;
      expired_mask_o <= 4'(mask_q);
    end
  end

  a_rmw_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == frt_pkg::FSM_RMW |-> $past(state_q) == frt_pkg::FSM_LOOK)
    else $error("record cycle without lookup");

  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == frt_pkg::FSM_LOOK)
    else $error("accepted beat did not start a lookup");

  a_complete_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && complete_o |-> status_o == frt_pkg::ST_ACCEPTED)
    else $error("completion on a rejected fragment");

  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != frt_pkg::ST_ACCEPTED |-> write_offset_o == 16'd0)
    else $error("offset on a rejected fragment");

endmodule
